[rtl/ipv4al_pkg.sv]
// shared types, command codes and octet compare for the ipv4 range allow list
`default_nettype none

package ipv4al_pkg;

    localparam int ADDR_W  = 32;
    localparam int OCTETS  = 4;
    localparam int OCTET_W = 8;

    // command codes carried on the input tuser
    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic cap_check;   // capture address, rewind scan
        logic do_insert;   // append entry unless full
        logic do_clear;    // empty the table
        logic scan_rd;     // read entry at scan index
        logic res_load;    // load output register
        logic res_scan;    // result comes from scan hit
        logic res_ins;     // result carries insert refusal
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_more;   // entries left to read
        logic rd_pending;  // read data still to compare
        logic out_free;    // output register free this cycle
    } t_dp_stat;

    // every octet of addr within the entry's own inclusive bounds
    function automatic logic octets_within(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] lo,
        input logic [ADDR_W-1:0] hi
    );
        logic ok;
        logic [OCTET_W-1:0] a;
        logic [OCTET_W-1:0] l;
        logic [OCTET_W-1:0] h;
        ok = 1'b1;
        for (int k = 0; k < OCTETS; k++) begin
            a = addr[k*OCTET_W +: OCTET_W];
            l = lo[k*OCTET_W +: OCTET_W];
            h = hi[k*OCTET_W +: OCTET_W];
            if (a < l || a > h) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[rtl/ipv4al_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ipv4al_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/ipv4al_ctrl.sv]
// controller state machine: item intake, table scan sequencing, result hand-off
`default_nettype none

module ipv4al_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic [1:0]           i_cmd,
    output logic                      o_s_tready,
    input  wire ipv4al_pkg::t_dp_stat i_stat,
    output ipv4al_pkg::t_dp_cmd       o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_s_tready = (r_state == ST_IDLE) && i_stat.out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        ipv4al_pkg::CMD_CHECK: begin
                            o_cmd.cap_check = 1'b1;
                            n_state         = ST_SCAN;
                        end
                        ipv4al_pkg::CMD_INSERT: begin
                            o_cmd.do_insert = 1'b1;
                            o_cmd.res_load  = 1'b1;
                            o_cmd.res_ins   = 1'b1;
                        end
                        ipv4al_pkg::CMD_CLEAR: begin
                            o_cmd.do_clear = 1'b1;
                            o_cmd.res_load = 1'b1;
                        end
                        default: begin
                            // unused code: zero result, table untouched
                            o_cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = i_stat.scan_more;
                if (!i_stat.scan_more && !i_stat.rd_pending) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_scan = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/ipv4al_dp.sv]
// datapath: entry table, scan index, octet compare, hit flag and output register
`default_nettype none

module ipv4al_dp #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ipv4al_pkg::ADDR_W-1:0] i_check_address,
    input  wire logic [ipv4al_pkg::ADDR_W-1:0] i_range_low,
    input  wire logic [ipv4al_pkg::ADDR_W-1:0] i_range_high,
    input  wire ipv4al_pkg::t_dp_cmd           i_cmd,
    output ipv4al_pkg::t_dp_stat               o_stat,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic                               o_allowed,
    output logic                               o_insert_refused
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = 2 * ipv4al_pkg::ADDR_W;

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_idx;
    logic [ipv4al_pkg::ADDR_W-1:0] r_addr;
    logic                          r_rd_vld;
    logic                          r_hit;
    logic                          r_out_vld;
    logic                          r_allowed;
    logic                          r_refused;
    logic                          full;
    logic                          ram_we;
    logic [EW-1:0]                 rdata;

    assign full   = (r_count == CW'(MAX_ENTRIES));
    assign ram_we = i_cmd.do_insert && !full;

    ipv4al_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_range_high, i_range_low}),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rdata)
    );

    assign o_stat.scan_more  = (r_idx < r_count);
    assign o_stat.rd_pending = r_rd_vld;
    assign o_stat.out_free   = !r_out_vld || i_m_tready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.do_clear) begin
                r_count <= '0;
            end else if (ram_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.cap_check) begin
                r_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_idx <= r_idx + CW'(1);
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_check) begin
            r_addr <= i_check_address;
            r_hit  <= 1'b0;
        end else if (r_rd_vld && ipv4al_pkg::octets_within(
                r_addr, rdata[ipv4al_pkg::ADDR_W-1:0], rdata[EW-1:ipv4al_pkg::ADDR_W])) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.res_load) begin
            r_allowed <= i_cmd.res_scan && r_hit;
            r_refused <= i_cmd.res_ins && full;
        end
    end

    assign o_m_tvalid       = r_out_vld;
    assign o_allowed        = r_allowed;
    assign o_insert_refused = r_refused;

endmodule

`default_nettype wire

[rtl/ipv4_octet_range_allow_list.sv]
// top level of the ipv4 per-octet range allow list
`default_nettype none

// Keeps up to MAX_ENTRIES allowed ranges, each with an inclusive lower and
// upper bound per octet (octet 0 in bits 7..0). Each input transfer carries
// a command on tuser: check (answer allowed when any stored entry holds all
// four address octets within its own bounds), insert (append an entry, or
// report insert_refused when the table is full) or clear (empty the table);
// code 3 is ignored and answers zeros. Every input transfer yields exactly one
// output transfer. Insert, clear and the unused code answer on the cycle after
// acceptance. A check scans the table one entry per cycle through the single
// read port of the entry ram and answers once every stored entry has been read
// and compared. Items are handled one at a time; a new item is taken once the
// block is idle and the output register is free or being drained in the same
// cycle. Entry storage needs no clearing after reset: only entries below the
// fill count are ever read.
module ipv4_octet_range_allow_list #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [95:0] i_s_tdata,  // check_address[31:0], range_low[63:32],
                                         // range_high[95:64]
    input  wire logic [1:0]  i_s_tuser,  // cmd[1:0]
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata   // allowed[0], insert_refused[1], zero[7:2]
);

    ipv4al_pkg::t_dp_cmd  dp_cmd;
    ipv4al_pkg::t_dp_stat dp_stat;
    logic                 allowed;
    logic                 insert_refused;

    // sequencing: intake, scan steps, result load
    ipv4al_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_cmd     (i_s_tuser),
        .o_s_tready(o_s_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // table, compare and output register
    ipv4al_dp #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_check_address (i_s_tdata[31:0]),
        .i_range_low     (i_s_tdata[63:32]),
        .i_range_high    (i_s_tdata[95:64]),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_allowed       (allowed),
        .o_insert_refused(insert_refused)
    );

    // pad result flags out to a whole byte
    assign o_m_tdata = {6'b0, insert_refused, allowed};

endmodule

`default_nettype wire

[rtl/ipv4al_chk.sv]
// port-level checker for the ipv4 range allow list, bound to the top level
`default_nettype none

module ipv4al_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [1:0]  i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output transfer dropped while stalled");

    // no intake while an undelivered result is stuck
    a_no_intake_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input ready while output stalled");

    // clear and unused code answer next cycle with both flags low
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != ipv4al_pkg::CMD_CHECK
            && i_s_tuser != ipv4al_pkg::CMD_INSERT
        |=> o_m_tvalid && o_m_tdata[1:0] == 2'b00)
        else $error("clear result wrong or late");

    // insert answers next cycle and never claims allowed
    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == ipv4al_pkg::CMD_INSERT
        |=> o_m_tvalid && !o_m_tdata[0])
        else $error("insert result wrong or late");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind ipv4_octet_range_allow_list ipv4al_chk u_ipv4al_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tuser (i_s_tuser),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

`default_nettype wire
